FILE: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

  // Frame geometry: start byte, 23 payload bytes, end byte.
  localparam int FrameBytes   = 25;
  localparam int PayloadBytes = FrameBytes - 2;
  localparam int ChanBytes    = PayloadBytes - 1;
  localparam int PayloadW     = ChanBytes * 8;
  localparam int ChanBits     = 11;
  localparam int ChanMax      = 16;
  localparam int PosBits      = 5;
  localparam int CounterBitsDef = 32;
  localparam int OutCntW      = 32;

  // Frame positions of the flags byte and of the end byte.
  localparam logic [PosBits-1:0] FlagsPos = PosBits'(PayloadBytes);
  localparam logic [PosBits-1:0] EndPos   = PosBits'(FrameBytes - 1);

  // Register indexes of the configuration port.
  localparam logic [1:0] CfgStart = 2'd0;
  localparam logic [1:0] CfgEnd   = 2'd1;
  localparam logic [1:0] CfgChans = 2'd2;

  // Register reset values.
  localparam logic [7:0] StartRst = 8'h0F;
  localparam logic [7:0] EndRst   = 8'h00;
  localparam logic [4:0] ChansRst = 5'd16;

  // Result kinds.
  localparam logic KindChan = 1'b0;
  localparam logic KindErr  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_byte;
    logic       drop_byte;
    logic       shift_payload;
    logic       store_flags;
    logic       good_frame;
    logic       bad_frame;
    logic       load_chan;
    logic       load_err;
    logic       last;
    logic [3:0] chan_idx;
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       is_start;
    logic       is_end;
    logic [4:0] emit_n;
    logic       out_free;
  } sfr_sts_t;

endpackage

FILE: rtl/sfr_dp.sv
`timescale 1ns / 1ps
module sfr_dp #(
  parameter int CounterBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [7:0]          rx_byte_i,
  input  sfr_pkg::sfr_cmd_t   cmd_i,
  output sfr_pkg::sfr_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                result_kind_o,
  output logic [3:0]          channel_index_o,
  output logic [10:0]         channel_value_o,
  output logic [7:0]          flag_bits_o,
  output logic                last_of_run_o,
  output logic [31:0]         good_frame_count_o,
  output logic [31:0]         bad_frame_count_o,
  output logic [31:0]         dropped_byte_count_o,
  output logic [31:0]         received_byte_count_o
);
  import sfr_pkg::*;

  localparam logic [CounterBits-1:0] CntMax   = '1;
  localparam logic [CounterBits-1:0] FrameCnt = CounterBits'(FrameBytes);

  logic [7:0]             start_q, end_q;
  logic [4:0]             chans_q;
  logic [PayloadW-1:0]    pay_q;
  logic [7:0]             flags_q;
  logic [CounterBits-1:0] good_q, bad_q, drop_q, recv_q;
  logic [CounterBits-1:0] drop_amt;
  logic                   out_valid_q;
  logic                   kind_q, last_q;
  logic [3:0]             idx_q;
  logic [ChanBits-1:0]    val_q;
  logic [7:0]             oflags_q;
  logic [OutCntW-1:0]     ogood_q, obad_q, odrop_q, orecv_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartRst;
      end_q   <= EndRst;
      chans_q <= ChansRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStart: start_q <= cfg_data_i;
        CfgEnd:   end_q   <= cfg_data_i;
        CfgChans: chans_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Status towards the controller; emit counts above sixteen clamp.
  always_comb begin
    sts_o.is_start = (rx_byte_i == start_q);
    sts_o.is_end   = (rx_byte_i == end_q);
    sts_o.emit_n   = (chans_q > 5'(ChanMax)) ? 5'(ChanMax) : chans_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Payload shift line: bytes enter at the top, channels leave at the bottom.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_payload) begin
      pay_q <= {rx_byte_i, pay_q[PayloadW-1:8]};
    end else if (cmd_i.load_chan) begin
      pay_q <= {{ChanBits{1'b0}}, pay_q[PayloadW-1:ChanBits]};
    end
    if (cmd_i.store_flags) begin
      flags_q <= rx_byte_i;
    end
  end

  assign drop_amt = cmd_i.bad_frame ? FrameCnt : CounterBits'(1);

  // Saturating statistics counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q <= '0;
      bad_q  <= '0;
      drop_q <= '0;
      recv_q <= '0;
    end else begin
      if (cmd_i.take_byte && recv_q != CntMax) begin
        recv_q <= recv_q + CounterBits'(1);
      end
      if (cmd_i.good_frame && good_q != CntMax) begin
        good_q <= good_q + CounterBits'(1);
      end
      if (cmd_i.bad_frame && bad_q != CntMax) begin
        bad_q <= bad_q + CounterBits'(1);
      end
      if (cmd_i.drop_byte || cmd_i.bad_frame) begin
        drop_q <= (drop_q > CntMax - drop_amt) ? CntMax : drop_q + drop_amt;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_chan || cmd_i.load_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload, with a snapshot of the counters.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_chan || cmd_i.load_err) begin
      kind_q   <= cmd_i.load_err ? KindErr : KindChan;
      idx_q    <= cmd_i.load_err ? 4'd0 : cmd_i.chan_idx;
      val_q    <= cmd_i.load_err ? '0 : pay_q[ChanBits-1:0];
      oflags_q <= cmd_i.load_err ? 8'd0 : flags_q;
      last_q   <= cmd_i.last;
      ogood_q  <= OutCntW'(good_q);
      obad_q   <= OutCntW'(bad_q);
      odrop_q  <= OutCntW'(drop_q);
      orecv_q  <= OutCntW'(recv_q);
    end
  end

  assign out_valid_o           = out_valid_q;
  assign result_kind_o         = kind_q;
  assign channel_index_o       = idx_q;
  assign channel_value_o       = val_q;
  assign flag_bits_o           = oflags_q;
  assign last_of_run_o         = last_q;
  assign good_frame_count_o    = ogood_q;
  assign bad_frame_count_o     = obad_q;
  assign dropped_byte_count_o  = odrop_q;
  assign received_byte_count_o = orecv_q;

endmodule

FILE: rtl/sfr_ctrl.sv
`timescale 1ns / 1ps
module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfr_pkg::sfr_sts_t sts_i,
  output sfr_pkg::sfr_cmd_t cmd_o
);
  import sfr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic               state_q, state_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [3:0]         chan_q, chan_d;
  logic               err_q, err_d;

  // Sequencer: frame position tracking while idle, one result per cycle in emit while the output register is free.
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    chan_d     = chan_q;
    err_d      = err_q;
    cmd_o      = '0;
    cmd_o.chan_idx = chan_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_byte = 1'b1;
          if (pos_q == '0) begin
            if (sts_i.is_start) begin
              pos_d = PosBits'(1);
            end else begin
              cmd_o.drop_byte = 1'b1;
            end
          end else if (pos_q < EndPos) begin
            if (pos_q == FlagsPos) begin
              cmd_o.store_flags = 1'b1;
            end else begin
              cmd_o.shift_payload = 1'b1;
            end
            pos_d = pos_q + PosBits'(1);
          end else begin
            pos_d  = '0;
            chan_d = 4'd0;
            if (sts_i.is_end) begin
              cmd_o.good_frame = 1'b1;
              err_d = 1'b0;
              if (sts_i.emit_n != 5'd0) begin
                state_d = S_EMIT;
              end
            end else begin
              cmd_o.bad_frame = 1'b1;
              err_d   = 1'b1;
              state_d = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          if (err_q) begin
            cmd_o.load_err = 1'b1;
            cmd_o.last     = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.load_chan = 1'b1;
            cmd_o.last      = ({1'b0, chan_q} + 5'd1 == sts_i.emit_n);
            chan_d          = chan_q + 4'd1;
            if (cmd_o.last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      chan_q  <= 4'd0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      chan_q  <= chan_d;
      err_q   <= err_d;
    end
  end

  // The frame position never runs past the end byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= EndPos)
    else $error("frame position out of range");

  // Results are only produced between frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> pos_q == '0)
    else $error("emitting results in the middle of a frame");

  // A wrong end byte always leads to an error result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && pos_q == EndPos && !sts_i.is_end)
      |=> (state_q == S_EMIT && err_q))
    else $error("end byte mismatch not reported");

  // The last channel result returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_chan && cmd_o.last) |=> state_q == S_IDLE)
    else $error("emission did not stop after the last channel");

endmodule

FILE: rtl/sbus_frame_receiver.sv
`timescale 1ns / 1ps
// Byte-serial receiver for 25-byte frames carrying sixteen 11-bit channels.
// Bytes are taken while no results are pending. The end byte of a correctly
// terminated frame then occupies the block while its channels are shifted
// out of the payload register into the output register one per cycle; a
// wrong end byte produces a single error transaction. No new byte is taken
// while a frame's results are being produced, and every output stall
// lengthens that time by its own length. The output register holds a
// snapshot of the four statistics counters, which saturate rather than wrap.
module sbus_frame_receiver #(
  parameter int CounterBits = sfr_pkg::CounterBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic [7:0]  flag_bits_o,
  output logic        last_of_run_o,
  output logic [31:0] good_frame_count_o,
  output logic [31:0] bad_frame_count_o,
  output logic [31:0] dropped_byte_count_o,
  output logic [31:0] received_byte_count_o
);
  import sfr_pkg::*;

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_dp #(
    .CounterBits (CounterBits)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .rx_byte_i             (rx_byte_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .result_kind_o         (result_kind_o),
    .channel_index_o       (channel_index_o),
    .channel_value_o       (channel_value_o),
    .flag_bits_o           (flag_bits_o),
    .last_of_run_o         (last_of_run_o),
    .good_frame_count_o    (good_frame_count_o),
    .bad_frame_count_o     (bad_frame_count_o),
    .dropped_byte_count_o  (dropped_byte_count_o),
    .received_byte_count_o (received_byte_count_o)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sfr_pkg::*;

  localparam int          CntBits     = 32;
  localparam logic [63:0] CntMax      = (64'd1 << CntBits) - 64'd1;
  localparam logic [1:0]  CfgUnused   = 2'd3;
  localparam int          DrainCycles = 40;
  localparam int          LongHold    = 400;
  localparam int          CycleLimit  = 200000;

  typedef enum {FillRandom, FillOnes, FillZeros, FillAlt} fill_e;

  // One expected or observed result transaction.
  typedef struct {
    logic        kind;
    logic [3:0]  chan;
    logic [10:0] value;
    logic [7:0]  flags;
    logic        last;
    logic [31:0] good;
    logic [31:0] bad;
    logic [31:0] dropped;
    logic [31:0] received;
  } chan_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [3:0]  channel_index_o;
  logic [10:0] channel_value_o;
  logic [7:0]  flag_bits_o;
  logic        last_of_run_o;
  logic [31:0] good_frame_count_o;
  logic [31:0] bad_frame_count_o;
  logic [31:0] dropped_byte_count_o;
  logic [31:0] received_byte_count_o;

  sbus_frame_receiver #(
    .CounterBits(CntBits)
  ) DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .rx_byte_i            (rx_byte_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .result_kind_o        (result_kind_o),
    .channel_index_o      (channel_index_o),
    .channel_value_o      (channel_value_o),
    .flag_bits_o          (flag_bits_o),
    .last_of_run_o        (last_of_run_o),
    .good_frame_count_o   (good_frame_count_o),
    .bad_frame_count_o    (bad_frame_count_o),
    .dropped_byte_count_o (dropped_byte_count_o),
    .received_byte_count_o(received_byte_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Byte stream waiting to be offered and results waiting to be seen.
  logic [7:0]   pending_bytes[$];
  chan_result_t pending_results[$];

  int send_idle_pct = 16;
  int recv_idle_pct = 63;
  int mismatches    = 0;
  int cycle_count   = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;

  // Decoder state mirrored on the testbench side.
  logic [7:0]  opener_cfg = StartRst;
  logic [7:0]  closer_cfg = EndRst;
  logic [4:0]  emit_cfg   = ChansRst;
  logic [4:0]  rx_pos     = '0;
  logic [7:0]  frame_data [PayloadBytes];
  logic [63:0] good_cnt   = '0;
  logic [63:0] bad_cnt    = '0;
  logic [63:0] drop_cnt   = '0;
  logic [63:0] rx_cnt     = '0;

  function automatic logic [63:0] counter_add(logic [63:0] v, logic [63:0] n);
    if (v > CntMax || CntMax - v < n) return CntMax;
    return v + n;
  endfunction

  // Channel c occupies stream bits 11c to 11c+10, bit 0 of byte 0 first.
  function automatic logic [10:0] channel_at(int c);
    logic [8*PayloadBytes-1:0] stream;
    for (int i = 0; i < PayloadBytes; i++) stream[i*8 +: 8] = frame_data[i];
    return stream[c*ChanBits +: ChanBits];
  endfunction

  function automatic chan_result_t make_result(logic kind, logic [3:0] chan,
                                               logic [10:0] value, logic [7:0] flags,
                                               logic last);
    chan_result_t r;
    r.kind     = kind;
    r.chan     = chan;
    r.value    = value;
    r.flags    = flags;
    r.last     = last;
    r.good     = good_cnt[31:0];
    r.bad      = bad_cnt[31:0];
    r.dropped  = drop_cnt[31:0];
    r.received = rx_cnt[31:0];
    return r;
  endfunction

  // Advances the mirrored decoder by one byte and queues what it emits.
  task automatic decode_rx_byte(input logic [7:0] b);
    int n;
    rx_cnt = counter_add(rx_cnt, 64'd1);
    if (rx_pos == 0) begin
      if (b == opener_cfg) rx_pos = 5'd1;
      else drop_cnt = counter_add(drop_cnt, 64'd1);
    end else if (rx_pos < EndPos) begin
      frame_data[rx_pos - 5'd1] = b;
      rx_pos++;
    end else begin
      rx_pos = '0;
      if (b == closer_cfg) begin
        n = (emit_cfg > ChanMax) ? ChanMax : int'(emit_cfg);
        good_cnt = counter_add(good_cnt, 64'd1);
        for (int c = 0; c < n; c++)
          pending_results.push_back(make_result(KindChan, 4'(c), channel_at(c),
                                                frame_data[PayloadBytes-1], c == n - 1));
      end else begin
        bad_cnt  = counter_add(bad_cnt, 64'd1);
        drop_cnt = counter_add(drop_cnt, 64'(FrameBytes));
        pending_results.push_back(make_result(KindErr, '0, '0, '0, 1'b1));
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Input driver: offers queued bytes, idling at random between transactions.
  always @(posedge clk_i) begin : byte_driver
    logic offer;
    offer = in_valid_i;
    if (in_valid_i && in_ready_o) begin
      decode_rx_byte(rx_byte_i);
      offer = 1'b0;
    end
    if (!offer && rst_ni && pending_bytes.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      rx_byte_i <= pending_bytes.pop_front();
      offer = 1'b1;
    end
    in_valid_i <= offer;
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin : result_receiver
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: each accepted transaction against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    chan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(result_kind_o), 32'(want.kind));
        check_field("channel_index", 32'(channel_index_o), 32'(want.chan));
        check_field("channel_value", 32'(channel_value_o), 32'(want.value));
        check_field("flag_bits", 32'(flag_bits_o), 32'(want.flags));
        check_field("last_of_run", 32'(last_of_run_o), 32'(want.last));
        check_field("good_frame_count", good_frame_count_o, want.good);
        check_field("bad_frame_count", bad_frame_count_o, want.bad);
        check_field("dropped_byte_count", dropped_byte_count_o, want.dropped);
        check_field("received_byte_count", received_byte_count_o, want.received);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sbus_frame_receiver verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgStart: opener_cfg = data;
      CfgEnd:   closer_cfg = data;
      CfgChans: emit_cfg   = data[4:0];
      default:  ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every byte is taken and every result seen, then lets the
  // block finish any trailing work.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_frame(input logic [7:0] opener, input logic [7:0] closer,
                             input fill_e fill);
    logic [7:0] b;
    pending_bytes.push_back(opener);
    for (int i = 0; i < PayloadBytes; i++) begin
      case (fill)
        FillOnes:  b = 8'hFF;
        FillZeros: b = 8'h00;
        FillAlt:   b = (i % 2 == 1) ? 8'h55 : 8'hAA;
        default:   b = 8'($urandom);
      endcase
      pending_bytes.push_back(b);
    end
    pending_bytes.push_back(closer);
  endtask

  // Mostly well-formed frames with random payload, the rest wrong end
  // bytes, cut-off frames and line noise.
  task automatic queue_random_traffic(input int byte_budget);
    int added;
    int pick;
    int len;
    @(negedge clk_i);
    added = 0;
    while (added < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_frame(opener_cfg, closer_cfg, FillRandom);
        added += FrameBytes;
      end else if (pick < 82) begin
        queue_frame(opener_cfg, closer_cfg ^ 8'($urandom_range(1, 255)), FillRandom);
        added += FrameBytes;
      end else if (pick < 90) begin
        len = $urandom_range(1, PayloadBytes);
        pending_bytes.push_back(opener_cfg);
        repeat (len) pending_bytes.push_back(8'($urandom));
        added += len + 1;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) pending_bytes.push_back(8'($urandom));
        added += len;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: noise, saturated, empty and alternating payloads, a wrong end byte.
    @(negedge clk_i);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    queue_frame(StartRst, EndRst, FillOnes);
    queue_frame(StartRst, EndRst, FillZeros);
    queue_frame(StartRst, EndRst, FillAlt);
    queue_frame(StartRst, 8'h55, FillRandom);
    wait_idle();

    // Emit count of zero: the frame counts but emits nothing.
    write_reg(CfgStart, 8'h00);
    write_reg(CfgEnd, 8'hFF);
    write_reg(CfgChans, 8'h00);
    @(negedge clk_i);
    queue_frame(8'h00, 8'hFF, FillRandom);
    wait_idle();

    // Emit counts above sixteen, and a write to an index with no register.
    write_reg(CfgStart, 8'hFF);
    write_reg(CfgChans, 8'hFF);
    write_reg(CfgUnused, 8'h01);
    @(negedge clk_i);
    queue_frame(8'hFF, 8'hFF, FillOnes);
    wait_idle();
    write_reg(CfgChans, 8'h11);
    @(negedge clk_i);
    queue_frame(8'hFF, 8'hFF, FillAlt);
    wait_idle();

    // A single channel per frame, and a frame with a wrong end byte.
    write_reg(CfgChans, 8'h01);
    @(negedge clk_i);
    queue_frame(8'hFF, 8'hFF, FillRandom);
    queue_frame(8'hFF, 8'h00, FillRandom);
    wait_idle();

    // Random traffic at reset settings: slow receiver.
    write_reg(CfgStart, StartRst);
    write_reg(CfgEnd, EndRst);
    write_reg(CfgChans, 8'(ChansRst));
    queue_random_traffic(25);
    wait_idle();

    // Random markers and emit count: slow sender.
    send_idle_pct = 63;
    recv_idle_pct = 16;
    write_reg(CfgStart, 8'($urandom));
    write_reg(CfgEnd, 8'($urandom));
    write_reg(CfgChans, 8'($urandom));
    queue_random_traffic(25);
    wait_idle();

    // No idling, with one long receiver hold-off so that the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgStart, 8'hA5);
    write_reg(CfgEnd, 8'h5A);
    write_reg(CfgChans, 8'd16);
    @(negedge clk_i);
    hold_req = ~hold_req;
    queue_frame(8'hA5, 8'h5A, FillRandom);
    queue_random_traffic(25);
    wait_idle();

    if (mismatches == 0) begin
      $display("sbus_frame_receiver verification clean");
    end else begin
      $display("sbus_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
